// File: rtl/wdtf_pkg.sv
// Types and constants shared by the wide decimal text to float converter.
package wdtf_pkg;

  localparam int MAX_LEN_DEF = 4095;
  localparam int EXP_W = 11;
  localparam int SIG_W = 48;
  localparam int DIV_STEPS = 13;

  localparam logic [31:0] F_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F_TEN  = 32'h4120_0000;
  localparam logic [31:0] F_QNAN = 32'hFFC0_0000;

  localparam logic [20:0] CH_TAB   = 21'h09;
  localparam logic [20:0] CH_CR    = 21'h0D;
  localparam logic [20:0] CH_SP    = 21'h20;
  localparam logic [20:0] CH_PLUS  = 21'h2B;
  localparam logic [20:0] CH_MINUS = 21'h2D;
  localparam logic [20:0] CH_DOT   = 21'h2E;
  localparam logic [20:0] CH_0     = 21'h30;
  localparam logic [20:0] CH_9     = 21'h39;
  localparam logic [20:0] CH_UE    = 21'h45;
  localparam logic [20:0] CH_LE    = 21'h65;

  typedef enum logic [2:0] {
    PH_SPACE, PH_INT, PH_FRAC, PH_EXPSIGN, PH_EXPDIG, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_NORM, ST_DEN, ST_RND, ST_WB
  } state_t;

  typedef enum logic [2:0] {
    JB_MUL10, JB_ADDD, JB_FRAC, JB_POW, JB_FINAL
  } job_t;

  typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_DIV} op_t;

  typedef struct packed {
    logic        first;
    logic [20:0] character;
  } req_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [11:0] consumed;
  } res_t;

endpackage

// File: rtl/wide_decimal_text_to_float_core.sv
// Top level of the wide decimal text to float converter.
//
// One character is taken per request while the block is idle. A white space, sign, dot,
// exponent letter or exponent digit is handled in the accepting cycle, and the block stays
// idle. A mantissa digit runs a float multiply by ten and a float add through the shared
// float unit. The end of a string runs one float divide per fraction digit, one multiply or
// divide per unit of exponent and a final multiply on the same unit. Each result is then
// normalized and denormalized one shift bit at a time; the divider retires four quotient
// bits a cycle. A multiply with a zero or infinite operand, an add to an infinite value or
// a divide of a zero or infinite value goes straight to write-back. The result waits in an
// output register; the next string may start while it is not yet taken.
module wide_decimal_text_to_float_core
  import wdtf_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_data
);

  localparam int PosW = $clog2(MAX_LEN + 1);

  state_t st, st_next;
  job_t   job;

  phase_t            phase;
  logic              neg, eneg, seen;
  logic [7:0]        fc;
  logic [6:0]        em;
  logic [PosW-1:0]   pos;

  logic [31:0]       acc, pw, res;
  logic [3:0]        dig;
  logic [7:0]        cnt;

  logic                    s_sign, stk;
  logic [SIG_W-1:0]        sig;
  logic signed [EXP_W-1:0] ex;
  logic [51:0]             num;
  logic [3:0]              rem;
  logic [3:0]              dcnt;

  logic accept;
  logic fin_load;

  phase_t          ph_e, ph_n;
  logic            neg_e, neg_n, eneg_e, eneg_n, seen_e, seen_n;
  logic [7:0]      fc_e, fc_n;
  logic [6:0]      em_e, em_n;
  logic [PosW-1:0] pos_e, pos_n;
  logic            do_dig, do_fin, adv;
  logic            is_dig, is_sp, is_sign, is_e;
  logic            int_path, frac_path, expd;
  logic [20:0]     c;
  logic [10:0]     em_calc;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (st != ST_IDLE);
  assign fin_load  = (st == ST_WB) && (job == JB_FINAL) && !(res_valid && res_stall);

  always_comb begin
    c       = req_data.character;
    is_dig  = (c >= CH_0) && (c <= CH_9);
    is_sp   = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    is_sign = (c == CH_PLUS) || (c == CH_MINUS);
    is_e    = (c == CH_LE) || (c == CH_UE);
    ph_e    = req_data.first ? PH_SPACE : phase;
    neg_e   = req_data.first ? 1'b0 : neg;
    eneg_e  = req_data.first ? 1'b0 : eneg;
    seen_e  = req_data.first ? 1'b0 : seen;
    fc_e    = req_data.first ? 8'd0 : fc;
    em_e    = req_data.first ? 7'd0 : em;
    pos_e   = req_data.first ? '0 : pos;
    ph_n    = ph_e;
    neg_n   = neg_e;
    eneg_n  = eneg_e;
    seen_n  = seen_e;
    fc_n    = fc_e;
    em_n    = em_e;
    pos_n   = pos_e;
    do_dig  = 1'b0;
    do_fin  = 1'b0;
    adv     = 1'b0;
    int_path  = 1'b0;
    frac_path = 1'b0;
    expd      = 1'b0;
    em_calc   = 11'({4'd0, em_e} * 11'd10) + 11'(c[3:0]);
    case (ph_e)
      PH_SPACE: begin
        if (is_sp) begin
          adv = 1'b1;
        end else begin
          ph_n = PH_INT;
          if (is_sign) begin
            neg_n = (c == CH_MINUS);
            adv   = 1'b1;
          end else begin
            int_path = 1'b1;
          end
        end
      end
      PH_INT:   int_path = 1'b1;
      PH_FRAC:  frac_path = 1'b1;
      PH_EXPSIGN: begin
        ph_n = PH_EXPDIG;
        if (is_sign) begin
          eneg_n = (c == CH_MINUS);
          adv    = 1'b1;
        end else begin
          expd = 1'b1;
        end
      end
      PH_EXPDIG: expd = 1'b1;
      default: ;
    endcase
    if (int_path) begin
      if (is_dig) begin
        do_dig = 1'b1;
        adv    = 1'b1;
      end else if (c == CH_DOT) begin
        ph_n = PH_FRAC;
        adv  = 1'b1;
      end else if (is_e) begin
        ph_n = PH_EXPSIGN;
        adv  = 1'b1;
      end else begin
        do_fin = 1'b1;
      end
    end
    if (frac_path) begin
      if (is_dig) begin
        do_dig = 1'b1;
        adv    = 1'b1;
        if (fc_e != 8'd255) fc_n = fc_e + 8'd1;
      end else if (is_e) begin
        ph_n = PH_EXPSIGN;
        adv  = 1'b1;
      end else begin
        do_fin = 1'b1;
      end
    end
    if (expd) begin
      if (is_dig) begin
        em_n = (em_calc > 11'd99) ? 7'd99 : em_calc[6:0];
        adv  = 1'b1;
      end else begin
        do_fin = 1'b1;
      end
    end
    if (do_fin) ph_n = PH_DONE;
    if (do_dig) seen_n = 1'b1;
    if (adv && (pos_e < PosW'(MAX_LEN))) pos_n = pos_e + PosW'(1);
  end

  // shared float unit: operand select and first step
  op_t                     opk;
  logic [31:0]             opa, opb;
  logic                    a_inf, b_inf, a_zero, b_zero;
  logic [23:0]             ma, mb;
  logic signed [EXP_W-1:0] ea, eb, sh;
  logic [5:0]              sh6;
  logic [SIG_W-1:0]        dsh, dmask, dfull;
  logic [SIG_W:0]          sum;
  logic                    x_spec, x_sign, x_stk;
  logic [31:0]             x_bits;
  logic [SIG_W-1:0]        x_sig;
  logic signed [EXP_W-1:0] x_ex;

  always_comb begin
    opk = OP_MUL;
    opa = acc;
    opb = F_TEN;
    case (job)
      JB_MUL10: opk = OP_MUL;
      JB_ADDD:  opk = OP_ADD;
      JB_FRAC:  opk = OP_DIV;
      JB_POW: begin
        opa = pw;
        opk = eneg ? OP_DIV : OP_MUL;
      end
      JB_FINAL: begin
        opa = {acc[31] ^ neg, acc[30:0]};
        opb = pw;
      end
      default: ;
    endcase
    a_inf  = (opa[30:23] == 8'hFF);
    b_inf  = (opb[30:23] == 8'hFF);
    a_zero = (opa[30:0] == 31'd0);
    b_zero = (opb[30:0] == 31'd0);
    ma     = {opa[30:23] != 8'd0, opa[22:0]};
    mb     = {opb[30:23] != 8'd0, opb[22:0]};
    ea     = (opa[30:23] == 8'd0) ? -11'sd126 : $signed({3'd0, opa[30:23]}) - 11'sd127;
    eb     = (opb[30:23] == 8'd0) ? -11'sd126 : $signed({3'd0, opb[30:23]}) - 11'sd127;
    x_spec = 1'b0;
    x_bits = opa;
    x_sign = 1'b0;
    x_stk  = 1'b0;
    x_sig  = '0;
    x_ex   = '0;
    sh     = '0;
    sh6    = '0;
    dfull  = {dig, 44'd0};
    dsh    = '0;
    dmask  = '0;
    sum    = '0;
    case (opk)
      OP_MUL: begin
        x_sign = opa[31] ^ opb[31];
        if ((a_inf && b_zero) || (b_inf && a_zero)) begin
          x_spec = 1'b1;
          x_bits = F_QNAN;
        end else if (a_inf || b_inf) begin
          x_spec = 1'b1;
          x_bits = {x_sign, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
          x_spec = 1'b1;
          x_bits = {x_sign, 31'd0};
        end else begin
          x_sig = ma * mb;
          x_ex  = ea + eb + 11'sd1;
        end
      end
      OP_ADD: begin
        if (a_inf) begin
          x_spec = 1'b1;
        end else begin
          x_ex = a_zero ? 11'sd3 : ea;
          sh   = x_ex - 11'sd3;
          if (sh < 11'sd0) begin
            dsh = dfull;
          end else if (sh >= 11'sd48) begin
            x_stk = (dig != 4'd0);
          end else begin
            sh6   = sh[5:0];
            dsh   = dfull >> sh6;
            dmask = (48'd1 << sh6) - 48'd1;
            x_stk = |(dfull & dmask);
          end
          sum = {1'b0, (a_zero ? 24'd0 : ma), 24'd0} + {1'b0, dsh};
          if (sum[SIG_W]) begin
            x_sig = sum[SIG_W:1];
            x_stk = x_stk | sum[0];
            x_ex  = x_ex + 11'sd1;
          end else begin
            x_sig = sum[SIG_W-1:0];
          end
        end
      end
      OP_DIV: begin
        if (a_inf || a_zero) begin
          x_spec = 1'b1;
        end else begin
          x_ex = ea - 11'sd3;
        end
      end
      default: ;
    endcase
  end

  // divide by ten, four quotient bits per cycle
  logic [4:0]       r5;
  logic [3:0]       d_rem;
  logic [51:0]      d_num;
  logic [SIG_W-1:0] d_q;

  always_comb begin
    d_rem = rem;
    d_num = num;
    d_q   = sig;
    r5    = '0;
    for (int k = 0; k < 4; k++) begin
      r5    = {d_rem, d_num[51]};
      d_num = {d_num[50:0], 1'b0};
      if (r5 >= 5'd10) begin
        r5  = r5 - 5'd10;
        d_q = {d_q[SIG_W-2:0], 1'b1};
      end else begin
        d_q = {d_q[SIG_W-2:0], 1'b0};
      end
      d_rem = r5[3:0];
    end
  end

  // round and pack
  logic [23:0]             rm;
  logic [24:0]             rm25;
  logic                    rg, rs, rinc;
  logic signed [EXP_W-1:0] be;
  logic [31:0]             rnd_bits;

  always_comb begin
    rm   = sig[47:24];
    rg   = sig[23];
    rs   = (|sig[22:0]) | stk;
    rinc = rg & (rs | rm[0]);
    rm25 = {1'b0, rm} + 25'(rinc);
    be   = ex + 11'sd127;
    if (rm25[24]) begin
      rm = rm25[24:1];
      be = be + 11'sd1;
    end else begin
      rm = rm25[23:0];
    end
    if (sig == '0) begin
      rnd_bits = {s_sign, 31'd0};
    end else if (be >= 11'sd255) begin
      rnd_bits = {s_sign, 8'hFF, 23'd0};
    end else begin
      rnd_bits = {s_sign, (rm[23] ? be[7:0] : 8'd0), rm[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: if (accept && (do_dig || do_fin)) st_next = ST_EXEC;
      ST_EXEC: begin
        if (x_spec) st_next = ST_WB;
        else if (opk == OP_DIV) st_next = ST_DIV;
        else st_next = ST_NORM;
      end
      ST_DIV:  if (dcnt == 4'(DIV_STEPS - 1)) st_next = ST_NORM;
      ST_NORM: if ((sig == '0) || sig[SIG_W-1]) st_next = ST_DEN;
      ST_DEN:  if ((sig == '0) || (ex >= -11'sd126)) st_next = ST_RND;
      ST_RND:  st_next = ST_WB;
      ST_WB: begin
        case (job)
          JB_ADDD:  st_next = ST_IDLE;
          JB_FINAL: if (!(res_valid && res_stall)) st_next = ST_IDLE;
          default:  st_next = ST_EXEC;
        endcase
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      neg       <= 1'b0;
      eneg      <= 1'b0;
      seen      <= 1'b0;
      fc        <= '0;
      em        <= '0;
      pos       <= '0;
      acc       <= '0;
      job       <= JB_MUL10;
      res_valid <= 1'b0;
    end else begin
      if (fin_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (accept) begin
            phase <= ph_n;
            neg   <= neg_n;
            eneg  <= eneg_n;
            seen  <= seen_n;
            fc    <= fc_n;
            em    <= em_n;
            pos   <= pos_n;
            dig   <= c[3:0];
            pw    <= F_ONE;
            if (req_data.first) acc <= '0;
            if (do_dig) begin
              job <= JB_MUL10;
            end else if (fc_e != 8'd0) begin
              job <= JB_FRAC;
              cnt <= fc_e;
            end else if (em_e != 7'd0) begin
              job <= JB_POW;
              cnt <= 8'(em_e);
            end else begin
              job <= JB_FINAL;
            end
          end
        end
        ST_EXEC: begin
          res    <= x_bits;
          s_sign <= x_sign;
          sig    <= x_sig;
          ex     <= x_ex;
          stk    <= x_stk;
          num    <= {1'b0, ma, 27'd0};
          rem    <= '0;
          dcnt   <= '0;
        end
        ST_DIV: begin
          num  <= d_num;
          rem  <= d_rem;
          sig  <= d_q;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'(DIV_STEPS - 1)) stk <= (d_rem != 4'd0);
        end
        ST_NORM: begin
          if ((sig != '0) && !sig[SIG_W-1]) begin
            sig <= {sig[SIG_W-2:0], 1'b0};
            ex  <= ex - 11'sd1;
          end
        end
        ST_DEN: begin
          if ((sig != '0) && (ex < -11'sd126)) begin
            sig <= {1'b0, sig[SIG_W-1:1]};
            stk <= stk | sig[0];
            ex  <= ex + 11'sd1;
          end
        end
        ST_RND: res <= rnd_bits;
        ST_WB: begin
          case (job)
            JB_MUL10: begin
              acc <= res;
              job <= JB_ADDD;
            end
            JB_ADDD: acc <= res;
            JB_FRAC: begin
              acc <= res;
              if (cnt != 8'd1) begin
                cnt <= cnt - 8'd1;
              end else if (em != 7'd0) begin
                job <= JB_POW;
                cnt <= 8'(em);
              end else begin
                job <= JB_FINAL;
              end
            end
            JB_POW: begin
              pw  <= res;
              cnt <= cnt - 8'd1;
              if (cnt == 8'd1) job <= JB_FINAL;
            end
            JB_FINAL: begin
              if (fin_load) begin
                res_data.value_bits <= res;
                res_data.consumed   <= seen ? 12'(pos) : 12'd0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  a_res_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(st) == ST_WB) && ($past(job) == JB_FINAL))
    else $error("result raised outside the final step");

  a_norm_done: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DEN) && ($past(st) == ST_NORM) |-> (sig == '0) || sig[SIG_W-1])
    else $error("significand left unnormalized");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV) |-> (rem < 4'd10))
    else $error("divider remainder out of range");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV) || (st == ST_NORM) || (st == ST_DEN) |-> req_stall)
    else $error("request taken while the float unit is busy");

endmodule

// File: tb/tb_wide_decimal_text_to_float_core.sv
// Self-checking testbench for the wide decimal text to float converter.
`timescale 1ns / 1ps

module tb_wide_decimal_text_to_float_core;
  import wdtf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  wide_decimal_text_to_float_core u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  always #4 clk = ~clk;

  req_t pending_q[$];
  res_t conv_q[$];
  int n_items = 0;
  int n_strings = 0;
  int n_results = 0;
  int n_mismatch = 0;
  int cyc = 0;
  int hold_left = 0;
  bit held = 1'b0;
  bit fst;

  // predictor state
  phase_t ph = PH_DONE;
  logic neg;
  logic [31:0] acc;
  int fcnt;
  logic eneg;
  int emag;
  logic seen;
  int pos;

  function automatic real to_real(logic [31:0] b);
    logic [63:0] d;
    if (b[30:23] == 8'd0) return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** -149);
    if (b[30:23] == 8'hFF) d = {b[31], 11'h7FF, b[22:0], 29'h0};
    else d = {b[31], {3'b000, b[30:23]} + 11'd896, b[22:0], 29'h0};
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] to_single(real x);
    logic [63:0] d, sig, q, rem, half;
    int e, sh, base;
    d = $realtobits(x);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? F_QNAN : {d[63], 8'hFF, 23'h0};
    if (d[62:52] == 11'h0) return {d[63], 31'h0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {d[63], 8'hFF, 23'h0};
    sig = {11'h0, 1'b1, d[51:0]};
    if (e >= -126) begin
      sh = 29;
      base = e + 127;
    end else begin
      sh = 29 + (-126 - e);
      base = 0;
    end
    if (sh >= 63) return {d[63], 31'h0};
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (base == 0) return {d[63], q[30:0]};
    q = (64'(base - 1) << 23) + q;
    if (q[30:23] == 8'hFF) return {d[63], 8'hFF, 23'h0};
    return {d[63], q[30:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) * to_real(b));
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) + to_real(b));
  endfunction

  function automatic logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
    return to_single(to_real(a) / to_real(b));
  endfunction

  function automatic bit is_dig(logic [20:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  task automatic restart_parse();
    ph = PH_SPACE;
    neg = 1'b0;
    acc = 32'h0;
    fcnt = 0;
    eneg = 1'b0;
    emag = 0;
    seen = 1'b0;
    pos = 0;
  endtask

  task automatic bump_pos();
    if (pos < MAX_LEN_DEF) pos++;
  endtask

  task automatic add_digit(logic [20:0] c);
    acc = fadd(fmul(acc, F_TEN), to_single(real'(c - CH_0)));
    seen = 1'b1;
  endtask

  task automatic finish_number();
    logic [31:0] r, p, v;
    res_t x;
    r = acc;
    p = F_ONE;
    for (int i = 0; i < fcnt; i++) r = fdiv(r, F_TEN);
    for (int i = 0; i < emag; i++) p = eneg ? fdiv(p, F_TEN) : fmul(p, F_TEN);
    v = fmul(neg ? 32'hBF80_0000 : F_ONE, r);
    v = fmul(v, p);
    x.value_bits = v;
    x.consumed = seen ? 12'(pos) : 12'd0;
    conv_q.push_back(x);
    ph = PH_DONE;
  endtask

  task automatic convert_char(req_t it);
    logic [20:0] c;
    c = it.character;
    if (it.first) restart_parse();
    if (ph == PH_DONE) return;
    if (ph == PH_SPACE) begin
      if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
        bump_pos();
        return;
      end
      ph = PH_INT;
      if (c == CH_PLUS || c == CH_MINUS) begin
        neg = (c == CH_MINUS);
        bump_pos();
        return;
      end
    end
    if (ph == PH_INT) begin
      if (is_dig(c)) begin
        add_digit(c);
        bump_pos();
        return;
      end
      if (c == CH_DOT) begin
        ph = PH_FRAC;
        bump_pos();
        return;
      end
    end
    if (ph == PH_INT || ph == PH_FRAC) begin
      if (ph == PH_FRAC && is_dig(c)) begin
        add_digit(c);
        if (fcnt < 255) fcnt++;
        bump_pos();
        return;
      end
      if (c == CH_LE || c == CH_UE) begin
        ph = PH_EXPSIGN;
        bump_pos();
        return;
      end
      finish_number();
      return;
    end
    if (ph == PH_EXPSIGN) begin
      ph = PH_EXPDIG;
      if (c == CH_PLUS || c == CH_MINUS) begin
        eneg = (c == CH_MINUS);
        bump_pos();
        return;
      end
    end
    if (is_dig(c)) begin
      emag = emag * 10 + int'(c - CH_0);
      if (emag > 99) emag = 99;
      bump_pos();
      return;
    end
    finish_number();
  endtask

  task automatic push_ch(logic [20:0] c);
    pending_q.push_back('{first: fst, character: c});
    fst = 1'b0;
    n_items++;
  endtask

  task automatic push_text(string s);
    fst = 1'b1;
    n_strings++;
    for (int i = 0; i < s.len(); i++) push_ch(21'(s[i]));
    push_ch(21'h0);
  endtask

  task automatic push_digits(int n);
    for (int i = 0; i < n; i++) push_ch(CH_0 + 21'($urandom_range(9)));
  endtask

  task automatic push_random_string();
    int n;
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
        fst = $urandom_range(1);
        push_ch(21'($urandom_range(21'h10FFFF)));
      end
      return;
    end
    fst = 1'b1;
    n_strings++;
    n = $urandom_range(3);
    for (int i = 0; i < n; i++)
      push_ch($urandom_range(5) == 0 ? CH_SP : 21'($urandom_range(13, 9)));
    if ($urandom_range(2) == 0) push_ch($urandom_range(1) ? CH_MINUS : CH_PLUS);
    push_digits($urandom_range(99) < 5 ? $urandom_range(60, 40) : $urandom_range(9));
    if ($urandom_range(1)) begin
      push_ch(CH_DOT);
      push_digits($urandom_range(99) < 2 ? $urandom_range(300, 250) : $urandom_range(7));
    end
    if ($urandom_range(2) == 0) begin
      push_ch($urandom_range(1) ? CH_LE : CH_UE);
      if ($urandom_range(1)) push_ch($urandom_range(1) ? CH_MINUS : CH_PLUS);
      push_digits($urandom_range(99) < 3 ? $urandom_range(6, 3) : $urandom_range(3));
    end
    if ($urandom_range(99) >= 5)
      push_ch($urandom_range(1) ? 21'h0 : 21'($urandom_range(21'h10FFFF)));
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) push_ch(21'($urandom_range(21'h10FFFF)));
  endtask

  always @(posedge clk) cyc <= cyc + 1;

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) convert_char(req_data);
      if (!req_valid || !req_stall) begin
        if (pending_q.size() != 0 && ((cyc >= 2000 && cyc < 6000) || $urandom_range(99) >= 10)) begin
          req_valid <= 1'b1;
          req_data <= pending_q.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (!held && n_results >= 30) begin
      held <= 1'b1;
      hold_left <= 500;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !(cyc >= 2000 && cyc < 6000) && $urandom_range(99) < 10;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      n_results <= n_results + 1;
      if (conv_q.size() == 0) begin
        n_mismatch <= n_mismatch + 1;
        if (n_mismatch < 10)
          $display("unexpected result: value %h consumed %0d", res_data.value_bits,
                   res_data.consumed);
      end else begin
        if (res_data !== conv_q[0]) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10)
            $display("mismatch: expected value %h consumed %0d, got value %h consumed %0d",
                     conv_q[0].value_bits, conv_q[0].consumed, res_data.value_bits,
                     res_data.consumed);
        end
        void'(conv_q.pop_front());
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    push_text("0");
    push_text("-");
    push_text(" \t\n\013\f\r+1.5e3");
    push_text("-0");
    push_text("9999999999");
    push_text(".e5");
    push_text("1e");
    push_text("1e+");
    push_text("-2.5E-");
    push_text("1e99");
    push_text("1e-99");
    push_text("340282346638528859811704183484516925440");
    push_text("99999999999999999999999999999999999999999999999999e-99");
    push_text("0e99");
    push_text(".");
    fst = 1'b1;
    push_ch(CH_0 + 21'd7);
    push_ch(CH_DOT);
    fst = 1'b0;
    push_ch(21'h1F_FFFF & 21'h10_FFFF);
    push_ch(21'h0F_0000);
    while (n_items < 700) push_random_string();
    do @(posedge clk);
    while (pending_q.size() != 0 || req_valid || conv_q.size() != 0);
    while (n_items < 1400) push_random_string();
    do @(posedge clk);
    while (pending_q.size() != 0 || req_valid || conv_q.size() != 0);
    repeat (8000) @(posedge clk);
    $display("covered %0d characters in %0d strings, %0d results checked, %0d mismatches",
             n_items, n_strings, n_results, n_mismatch);
    if (n_mismatch == 0 && conv_q.size() == 0) begin
      $display("tb_wide_decimal_text_to_float_core: PASS");
    end else begin
      $display("tb_wide_decimal_text_to_float_core: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_wide_decimal_text_to_float_core: FAIL");
    $finish;
  end

endmodule
